[sv/stffm_pkg.sv]
// ----------------------------------------------------------------------------
// stffm_pkg
// Shared types and constants for the slot table with first-free allocation
// and filtered match-and-remove.
// ----------------------------------------------------------------------------
package stffm_pkg;

  // Field widths fixed by the item format
  localparam int unsigned IdxW   = 7;
  localparam int unsigned CoordW = 32;
  localparam int unsigned KindW  = 8;
  localparam int unsigned AmtW   = 16;
  localparam int unsigned FuncW  = 2;

  // Operation codes; code 3 is unused and does nothing
  typedef enum logic [FuncW-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_SCAN   = 2'd2
  } func_e;

  // Control sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_PICK
  } state_e;

  // One operation as broadcast to every cell
  typedef struct packed {
    logic [FuncW-1:0]  func;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              use_coord;
    logic [KindW-1:0]  kind;
    logic [AmtW-1:0]   amount;
    logic [IdxW-1:0]   start;
  } op_t;

  // Priority chain passed from cell to cell: claim marks that a lower slot
  // already won, the rest carries the winner's index and contents
  typedef struct packed {
    logic              claim;
    logic [IdxW-1:0]   idx;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [KindW-1:0]  kind;
    logic [AmtW-1:0]   amount;
  } chain_t;

endpackage

[sv/stffm_cell.sv]
// ----------------------------------------------------------------------------
// stffm_cell
// One table slot: stores an entry and its occupied bit, evaluates the
// broadcast operation against it, and takes part in the lowest-slot-wins
// priority chain.
// ----------------------------------------------------------------------------
module stffm_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      eval_en_i,
  input  stffm_pkg::op_t            eval_op_i,
  input  logic                      commit_en_i,
  input  stffm_pkg::op_t            commit_op_i,
  input  stffm_pkg::chain_t         chain_i,
  output stffm_pkg::chain_t         chain_o,
  output logic                      occ_o
);

  localparam logic [stffm_pkg::IdxW-1:0] MyIdx = Idx[stffm_pkg::IdxW-1:0];

  logic                          occ_q, occ_d;
  logic                          hit_q, hit_d;
  logic [stffm_pkg::CoordW-1:0]  x_q;
  logic [stffm_pkg::CoordW-1:0]  y_q;
  logic [stffm_pkg::KindW-1:0]   kind_q;
  logic [stffm_pkg::AmtW-1:0]    amount_q;
  logic                          kind_ok;
  logic                          coord_ok;
  logic                          sel;
  logic                          wr_en;

  // Per-slot match against the incoming operation
  always_comb begin
    kind_ok  = (eval_op_i.kind == '0) || (eval_op_i.kind == kind_q);
    coord_ok = !eval_op_i.use_coord ||
               ((eval_op_i.x == x_q) && (eval_op_i.y == y_q));
    unique case (stffm_pkg::func_e'(eval_op_i.func))
      stffm_pkg::FUNC_INSERT: hit_d = !occ_q;
      stffm_pkg::FUNC_REMOVE: hit_d = occ_q && kind_ok && coord_ok;
      stffm_pkg::FUNC_SCAN:   hit_d = occ_q && (eval_op_i.start <= MyIdx);
      default:                hit_d = 1'b0;
    endcase
  end

  // Priority chain: first hit from slot 0 upward wins
  assign sel = hit_q && !chain_i.claim;

  always_comb begin
    chain_o.claim  = chain_i.claim | hit_q;
    chain_o.idx    = chain_i.idx    | (sel ? MyIdx    : '0);
    chain_o.x      = chain_i.x      | (sel ? x_q      : '0);
    chain_o.y      = chain_i.y      | (sel ? y_q      : '0);
    chain_o.kind   = chain_i.kind   | (sel ? kind_q   : '0);
    chain_o.amount = chain_i.amount | (sel ? amount_q : '0);
  end

  // Commit: the winning slot is filled by insert or freed by remove
  always_comb begin
    occ_d = occ_q;
    wr_en = 1'b0;
    if (commit_en_i && sel) begin
      if (commit_op_i.func == stffm_pkg::FUNC_INSERT) begin
        occ_d = 1'b1;
        wr_en = 1'b1;
      end else if (commit_op_i.func == stffm_pkg::FUNC_REMOVE) begin
        occ_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      if (eval_en_i) begin
        hit_q <= hit_d;
      end
    end
  end

  // Entry payload, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      x_q      <= commit_op_i.x;
      y_q      <= commit_op_i.y;
      kind_q   <= commit_op_i.kind;
      amount_q <= commit_op_i.amount;
    end
  end

  assign occ_o = occ_q;

endmodule

[sv/slot_table_first_free_match_remove_unit.sv]
// ----------------------------------------------------------------------------
// slot_table_first_free_match_remove_unit
// Fixed slot table with lowest-free insert, filtered match-and-remove and
// scan for the next occupied slot, built as a row of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one operation item: insert,
//   remove with optional kind and coordinate filters, or scan from a start
//   index. Output channel (out_valid_o / out_stall_i) returns one result
//   item per operation with ok, slot index, entry contents and the
//   occupancy count after the operation.
//   Sequence: at the accept edge every cell registers its match; then the
//   priority chain through all CAPACITY cells picks the lowest matching
//   slot, commits the change and loads the output register.
//   Only one item is in flight at a time, for the match-then-pick pass
//   through the cell row; in_stall_o is high while an item is in flight.
//   A waiting result sits in the output register; a new item is still
//   accepted, and its pick step waits until that result is taken.
//   Reset empties the table (all occupied bits and the count cleared); slot
//   contents are not cleared and are only ever read from occupied slots.
// ----------------------------------------------------------------------------
module slot_table_first_free_match_remove_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] coord_x_i,
  input  logic [31:0] coord_y_i,
  input  logic        use_coord_i,
  input  logic [7:0]  item_kind_i,
  input  logic [15:0] amount_i,
  input  logic [6:0]  start_index_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        ok_o,
  output logic [6:0]  slot_index_o,
  output logic [31:0] out_coord_x_o,
  output logic [31:0] out_coord_y_o,
  output logic [7:0]  out_item_kind_o,
  output logic [15:0] out_amount_o,
  output logic [6:0]  occupied_total_o
);

  localparam logic [stffm_pkg::IdxW-1:0] CapIdx = CAPACITY[stffm_pkg::IdxW-1:0];

  stffm_pkg::state_e  state_q, state_d;
  stffm_pkg::op_t     in_op;
  stffm_pkg::op_t     op_q;
  stffm_pkg::chain_t  link [CAPACITY+1];
  stffm_pkg::chain_t  res;
  logic [CAPACITY-1:0] occ;
  logic                accept;
  logic                go;
  logic [stffm_pkg::IdxW-1:0] count_q, count_d;
  logic                out_valid_q, out_valid_d;
  logic                ok_q;
  logic [stffm_pkg::IdxW-1:0]   idx_q;
  logic [stffm_pkg::CoordW-1:0] x_q;
  logic [stffm_pkg::CoordW-1:0] y_q;
  logic [stffm_pkg::KindW-1:0]  kind_q;
  logic [stffm_pkg::AmtW-1:0]   amount_q;
  logic                         data_en;

  // Pack the incoming item
  always_comb begin
    in_op.func      = func_i;
    in_op.x         = coord_x_i;
    in_op.y         = coord_y_i;
    in_op.use_coord = use_coord_i;
    in_op.kind      = item_kind_i;
    in_op.amount    = amount_i;
    in_op.start     = start_index_i;
  end

  assign in_stall_o = (state_q != stffm_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  // Pick step runs once the output register is free or being emptied
  assign go = (state_q == stffm_pkg::ST_PICK) && (!out_valid_q || !out_stall_i);

  // Row of slot cells
  assign link[0] = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    stffm_cell #(
      .Idx (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .eval_en_i   (accept),
      .eval_op_i   (in_op),
      .commit_en_i (go),
      .commit_op_i (op_q),
      .chain_i     (link[g]),
      .chain_o     (link[g+1]),
      .occ_o       (occ[g])
    );
  end

  assign res = link[CAPACITY];

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stffm_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = stffm_pkg::ST_PICK;
        end
      end
      stffm_pkg::ST_PICK: begin
        if (go) begin
          state_d = stffm_pkg::ST_IDLE;
        end
      end
      default: state_d = stffm_pkg::ST_IDLE;
    endcase
  end

  // Occupancy count update
  always_comb begin
    count_d = count_q;
    if (go && res.claim) begin
      if (op_q.func == stffm_pkg::FUNC_INSERT) begin
        count_d = count_q + 7'd1;
      end else if (op_q.func == stffm_pkg::FUNC_REMOVE) begin
        count_d = count_q - 7'd1;
      end
    end
  end

  assign out_valid_d = go || (out_valid_q && out_stall_i);
  // Contents are returned for remove and scan hits only
  assign data_en     = res.claim && (op_q.func != stffm_pkg::FUNC_INSERT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stffm_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Operation and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= in_op;
    end
    if (go) begin
      ok_q     <= res.claim;
      idx_q    <= res.claim ? res.idx : CapIdx;
      x_q      <= data_en ? res.x      : '0;
      y_q      <= data_en ? res.y      : '0;
      kind_q   <= data_en ? res.kind   : '0;
      amount_q <= data_en ? res.amount : '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign ok_o             = ok_q;
  assign slot_index_o     = idx_q;
  assign out_coord_x_o    = x_q;
  assign out_coord_y_o    = y_q;
  assign out_item_kind_o  = kind_q;
  assign out_amount_o     = amount_q;
  assign occupied_total_o = count_q;

  // Checks
  a_count_matches_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(occ) == 32'(count_q))
    else $error("occupancy count differs from occupied bits");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapIdx)
    else $error("occupancy count above capacity");

  a_accept_to_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == stffm_pkg::ST_PICK))
    else $error("accepted item did not reach pick step");

  a_insert_counts_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && res.claim && (op_q.func == stffm_pkg::FUNC_INSERT))
      |=> (count_q == $past(count_q) + 7'd1))
    else $error("insert did not raise occupancy count");

  a_go_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> (out_valid_o && (ok_o == $past(res.claim))))
    else $error("pick step did not present its result");

endmodule
